// ===== rtl/sats_pkg.sv =====
// Shared types and constants for the star and raw-string token scanner.
// No dependencies; imported by sats_step and the top level.
package sats_pkg;

  // Scan phases.
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_WS         = 4'd1;
  localparam logic [3:0] PH_STAR_NEXT  = 4'd2;
  localparam logic [3:0] PH_HASHES     = 4'd3;
  localparam logic [3:0] PH_OPEN_Q     = 4'd4;
  localparam logic [3:0] PH_BODY       = 4'd5;
  localparam logic [3:0] PH_BLK_SPACES = 4'd6;
  localparam logic [3:0] PH_BLK_QUOTES = 4'd7;
  localparam logic [3:0] PH_BLK_HASHES = 4'd8;
  localparam logic [3:0] PH_SIMPLE     = 4'd9;
  localparam logic [3:0] PH_ESC_HASH   = 4'd10;
  localparam logic [3:0] PH_ESC_CHAR   = 4'd11;
  localparam logic [3:0] PH_CLOSE_HASH = 4'd12;

  // Token kinds.
  localparam logic [1:0] KIND_BINARY  = 2'd0;
  localparam logic [1:0] KIND_POSTFIX = 2'd1;
  localparam logic [1:0] KIND_STRING  = 2'd2;

  // Per-character actions.
  localparam logic [1:0] ACT_SKIPPED  = 2'd0;
  localparam logic [1:0] ACT_CONSUMED = 2'd1;
  localparam logic [1:0] ACT_NOT_CONS = 2'd2;
  localparam logic [1:0] ACT_IDLE     = 2'd3;

  // Mask bits.
  localparam int MASK_STRING = 2;

  // Characters of interest.
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;

  // Scan control state that does not depend on the hash bound.
  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] allowed;
    logic       saw_ws;
    logic [1:0] quote;
  } scan_ctl_t;

  // One result item; packs with action in the lowest bits.
  typedef struct packed {
    logic [1:0] kind;
    logic       acc;
    logic       done;
    logic [1:0] action;
  } scan_res_t;

  function automatic logic may_follow_binary(input logic [7:0] c);
    may_follow_binary = (c == 8'h5F) ||
                        (c >= 8'h61 && c <= 8'h7A) ||
                        (c >= 8'h41 && c <= 8'h5A) ||
                        (c == CH_DQ) ||
                        (c >= 8'h30 && c <= 8'h39) ||
                        (c == 8'h28) || (c == 8'h5B) || (c == 8'h7B);
  endfunction

endpackage

// ===== rtl/sats_step.sv =====
// Next-state and result logic for one character of the token scanner.
// Purely combinational; depends on sats_pkg.
module sats_step
  import sats_pkg::*;
#(
  parameter int MAX_HASHES = 255,
  localparam int HashW = $clog2(MAX_HASHES + 1)
) (
  input  logic             start_req,
  input  logic [2:0]       valid_mask,
  input  logic [7:0]       ch,
  input  logic             at_eof,
  input  scan_ctl_t        ctl_cur,
  input  logic [HashW-1:0] hash_target_cur,
  input  logic [HashW-1:0] hash_matched_cur,
  output scan_ctl_t        ctl_nxt,
  output logic [HashW-1:0] hash_target_nxt,
  output logic [HashW-1:0] hash_matched_nxt,
  output scan_res_t        res
);

  always_comb begin
    scan_ctl_t        e_ctl;
    logic [HashW-1:0] e_ht;
    logic [HashW-1:0] e_hm;
    logic [HashW-1:0] hm_inc;
    logic             hm_hit;
    logic             tgt_zero;
    logic             hash_full;
    logic [1:0]       q_inc;
    logic             is_ws;
    logic             fin;
    logic             fin_ok;
    logic [1:0]       fin_kind;
    logic             use_simple;
    logic             use_body;

    e_ctl = ctl_cur;
    e_ht  = hash_target_cur;
    e_hm  = hash_matched_cur;
    if (start_req) begin
      e_ctl.phase   = PH_WS;
      e_ctl.allowed = valid_mask;
      e_ctl.saw_ws  = 1'b0;
      e_ctl.quote   = 2'd0;
      e_ht          = '0;
      e_hm          = '0;
    end

    hm_inc    = e_hm + 1'b1;
    hm_hit    = hm_inc >= e_ht;
    tgt_zero  = e_ht == '0;
    hash_full = e_ht >= HashW'(MAX_HASHES);
    q_inc     = e_ctl.quote + 2'd1;
    is_ws     = (ch == CH_SPACE) || (ch == CH_LF);

    ctl_nxt          = e_ctl;
    hash_target_nxt  = e_ht;
    hash_matched_nxt = e_hm;
    res              = '{kind: KIND_BINARY, acc: 1'b0, done: 1'b0, action: ACT_IDLE};
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_kind   = KIND_BINARY;
    use_simple = 1'b0;
    use_body   = 1'b0;

    if (e_ctl.phase != PH_IDLE && at_eof && e_ctl.phase != PH_STAR_NEXT) begin
      fin        = 1'b1;
      res.action = ACT_NOT_CONS;
    end else begin
      case (e_ctl.phase)
        PH_WS: begin
          if (is_ws) begin
            ctl_nxt.saw_ws = 1'b1;
            res.action     = ACT_SKIPPED;
          end else if (ch == CH_STAR && e_ctl.allowed[1:0] != 2'b00) begin
            ctl_nxt.phase = PH_STAR_NEXT;
            res.action    = ACT_CONSUMED;
          end else if (e_ctl.allowed[MASK_STRING] && ch == CH_HASH) begin
            if (hash_full) begin
              fin        = 1'b1;
              res.action = ACT_NOT_CONS;
            end else begin
              hash_target_nxt = e_ht + 1'b1;
              ctl_nxt.phase   = PH_HASHES;
              res.action      = ACT_CONSUMED;
            end
          end else if (e_ctl.allowed[MASK_STRING] && ch == CH_SQ) begin
            ctl_nxt.quote = 2'd1;
            ctl_nxt.phase = PH_OPEN_Q;
            res.action    = ACT_CONSUMED;
          end else if (e_ctl.allowed[MASK_STRING] && ch == CH_DQ) begin
            ctl_nxt.phase = PH_SIMPLE;
            res.action    = ACT_CONSUMED;
          end else begin
            fin        = 1'b1;
            res.action = ACT_NOT_CONS;
          end
        end
        PH_STAR_NEXT: begin
          // The character after the star only decides the class.
          fin        = 1'b1;
          fin_ok     = 1'b1;
          res.action = ACT_NOT_CONS;
          if (!at_eof && is_ws && e_ctl.saw_ws) begin
            fin_kind = KIND_BINARY;
          end else if (!at_eof && !e_ctl.saw_ws && may_follow_binary(ch)) begin
            fin_kind = KIND_BINARY;
          end else begin
            fin_kind = KIND_POSTFIX;
          end
        end
        PH_HASHES: begin
          if (ch == CH_HASH) begin
            if (hash_full) begin
              fin        = 1'b1;
              res.action = ACT_NOT_CONS;
            end else begin
              hash_target_nxt = e_ht + 1'b1;
              ctl_nxt.phase   = PH_HASHES;
              res.action      = ACT_CONSUMED;
            end
          end else if (ch == CH_SQ) begin
            ctl_nxt.quote = 2'd1;
            ctl_nxt.phase = PH_OPEN_Q;
            res.action    = ACT_CONSUMED;
          end else if (ch == CH_DQ) begin
            ctl_nxt.phase = PH_SIMPLE;
            res.action    = ACT_CONSUMED;
          end else begin
            fin        = 1'b1;
            res.action = ACT_NOT_CONS;
          end
        end
        PH_OPEN_Q: begin
          if (ch == CH_SQ) begin
            res.action    = ACT_CONSUMED;
            ctl_nxt.quote = q_inc;
            if (q_inc == 2'd3) begin
              ctl_nxt.quote = 2'd0;
              ctl_nxt.phase = PH_BODY;
            end
          end else begin
            fin        = 1'b1;
            res.action = ACT_NOT_CONS;
          end
        end
        PH_BODY: begin
          use_body = 1'b1;
        end
        PH_BLK_SPACES: begin
          if (ch == CH_SPACE) begin
            res.action = ACT_CONSUMED;
          end else if (ch == CH_SQ) begin
            ctl_nxt.quote = 2'd1;
            ctl_nxt.phase = PH_BLK_QUOTES;
            res.action    = ACT_CONSUMED;
          end else begin
            use_body = 1'b1;
          end
        end
        PH_BLK_QUOTES: begin
          if (ch == CH_SQ) begin
            res.action    = ACT_CONSUMED;
            ctl_nxt.quote = q_inc;
            if (q_inc == 2'd3) begin
              ctl_nxt.quote = 2'd0;
              if (tgt_zero) begin
                fin      = 1'b1;
                fin_ok   = 1'b1;
                fin_kind = KIND_STRING;
              end else begin
                hash_matched_nxt = '0;
                ctl_nxt.phase    = PH_BLK_HASHES;
              end
            end
          end else begin
            ctl_nxt.quote = 2'd0;
            use_body      = 1'b1;
          end
        end
        PH_BLK_HASHES: begin
          if (ch == CH_HASH) begin
            hash_matched_nxt = hm_inc;
            res.action       = ACT_CONSUMED;
            if (hm_hit) begin
              fin      = 1'b1;
              fin_ok   = 1'b1;
              fin_kind = KIND_STRING;
            end
          end else begin
            use_body = 1'b1;
          end
        end
        PH_SIMPLE: begin
          use_simple = 1'b1;
        end
        PH_ESC_HASH: begin
          if (ch == CH_HASH) begin
            hash_matched_nxt = hm_inc;
            res.action       = ACT_CONSUMED;
            if (hm_hit) begin
              ctl_nxt.phase = PH_ESC_CHAR;
            end
          end else begin
            use_simple = 1'b1;
          end
        end
        PH_ESC_CHAR: begin
          if (ch == CH_LF) begin
            fin        = 1'b1;
            res.action = ACT_NOT_CONS;
          end else begin
            ctl_nxt.phase = PH_SIMPLE;
            res.action    = ACT_CONSUMED;
          end
        end
        PH_CLOSE_HASH: begin
          if (ch == CH_HASH) begin
            hash_matched_nxt = hm_inc;
            res.action       = ACT_CONSUMED;
            if (hm_hit) begin
              fin      = 1'b1;
              fin_ok   = 1'b1;
              fin_kind = KIND_STRING;
            end
          end else begin
            use_simple = 1'b1;
          end
        end
        default: begin
          ctl_nxt.phase = PH_IDLE;
          res.action    = ACT_IDLE;
        end
      endcase
    end

    // Ordinary block-string text; a newline opens a possible closing line.
    if (use_body) begin
      ctl_nxt.phase = (ch == CH_LF) ? PH_BLK_SPACES : PH_BODY;
      res.action    = ACT_CONSUMED;
    end

    // Ordinary simple-string text, also reached when a closer or escape breaks off.
    if (use_simple) begin
      res.action = ACT_CONSUMED;
      if (ch == CH_BSL) begin
        hash_matched_nxt = '0;
        ctl_nxt.phase    = tgt_zero ? PH_ESC_CHAR : PH_ESC_HASH;
      end else if (ch == CH_DQ) begin
        if (tgt_zero) begin
          fin      = 1'b1;
          fin_ok   = 1'b1;
          fin_kind = KIND_STRING;
        end else begin
          hash_matched_nxt = '0;
          ctl_nxt.phase    = PH_CLOSE_HASH;
        end
      end else if (ch == CH_LF) begin
        fin        = 1'b1;
        res.action = ACT_NOT_CONS;
      end else begin
        ctl_nxt.phase = PH_SIMPLE;
      end
    end

    if (fin) begin
      ctl_nxt.phase = PH_IDLE;
      res.done      = 1'b1;
      res.acc       = fin_ok;
      res.kind      = fin_ok ? fin_kind : KIND_BINARY;
    end
  end

endmodule

// ===== rtl/star_and_raw_string_token_scanner_top.sv =====
// Throughput: one character per cycle unless the result channel stalls; the input
// register, the combinational scanner step and the result register form a two-stage pipeline.
// Reset (rst_n low, synchronous) empties both stages and returns the scanner
// to idle with all counters cleared.
// Top level of the star and raw-string token scanner; uses sats_pkg and sats_step.
module star_and_raw_string_token_scanner_top
  import sats_pkg::*;
#(
  parameter int MAX_HASHES = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] valid_mask, [10:3] ch, [15:11] zero
  input  logic [1:0]  in_tuser,   // [0] start_req, [1] at_eof
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] action, [2] done_res, [3] accepted,
                                  // [5:4] token_kind, [7:6] zero
);

  localparam int HashW = $clog2(MAX_HASHES + 1);

  // Input register stage. Each accepted character is parked here and handed
  // to the scanner step together with the current state.
  logic       in_valid_r;
  logic       in_start_r;
  logic [2:0] in_mask_r;
  logic [7:0] in_ch_r;
  logic       in_eof_r;

  // Result register stage.
  logic      out_valid_r;
  scan_res_t out_res_r;

  // Scanner state.
  scan_ctl_t        ctl_r;
  logic [HashW-1:0] hash_target_r;
  logic [HashW-1:0] hash_matched_r;

  scan_ctl_t        ctl_nxt;
  logic [HashW-1:0] hash_target_nxt;
  logic [HashW-1:0] hash_matched_nxt;
  scan_res_t        res_nxt;

  logic out_free;
  logic advance;

  // The result register can take a new item when it is empty or its
  // contents leave in this cycle. The scanner state only moves on when the
  // character in the input register really passes into the result register.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_start_r <= in_tuser[0];
      in_eof_r   <= in_tuser[1];
      in_mask_r  <= in_tdata[2:0];
      in_ch_r    <= in_tdata[10:3];
    end
  end

  sats_step #(
    .MAX_HASHES (MAX_HASHES)
  ) u_step (
    .start_req        (in_start_r),
    .valid_mask       (in_mask_r),
    .ch               (in_ch_r),
    .at_eof           (in_eof_r),
    .ctl_cur          (ctl_r),
    .hash_target_cur  (hash_target_r),
    .hash_matched_cur (hash_matched_r),
    .ctl_nxt          (ctl_nxt),
    .hash_target_nxt  (hash_target_nxt),
    .hash_matched_nxt (hash_matched_nxt),
    .res              (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r          <= '{phase: PH_IDLE, allowed: 3'd0, saw_ws: 1'b0, quote: 2'd0};
      hash_target_r  <= '0;
      hash_matched_r <= '0;
    end else if (advance) begin
      ctl_r          <= ctl_nxt;
      hash_target_r  <= hash_target_nxt;
      hash_matched_r <= hash_matched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

`ifndef NO_ASSERTIONS
  // A decided scan always leaves the scanner idle.
  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.done |=> ctl_r.phase == PH_IDLE)
    else $error("scanner not idle after a decision");

  // The matched hash count never runs past the opening count.
  a_hash_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hash_matched_r <= hash_target_r)
    else $error("matched hashes exceed the opening count");

  // A character held in the input register is not overwritten while stalled.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r && $stable(in_ch_r) && $stable(in_start_r))
    else $error("stalled input register overwritten");

  // A result transfer reports an accepted token only together with a decision.
  a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.acc |-> out_res_r.done)
    else $error("accepted without a decision");
`endif

endmodule

// ===== tb/sv/tb_star_and_raw_string_token_scanner_top.sv =====
// Self-checking testbench for the star and raw-string token scanner top level.
// Depends on sats_pkg and star_and_raw_string_token_scanner_top; a scoreboard class
// predicts one result per input transfer and checks the result stream in order.
module tb_star_and_raw_string_token_scanner_top;
  import sats_pkg::*;

  localparam int MAX_HASHES   = 255;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;
  // Both star bits of the allowed-token mask.
  localparam logic [2:0] STAR_BITS = 3'b011;

  // Scoreboard: keeps its own copy of the scanner state, computes the result that
  // each accepted character causes and compares the result stream against it.
  class scan_scoreboard;
    logic [3:0] phase;
    logic [2:0] allowed;
    logic       saw_ws;
    logic [7:0] hash_tgt;
    logic [7:0] hash_cnt;
    logic [1:0] quotes;
    scan_res_t  res;
    scan_res_t  expected_q[$];
    int         errors;

    function new();
      clear_scan();
      errors = 0;
    endfunction

    function void clear_scan();
      phase    = PH_IDLE;
      allowed  = '0;
      saw_ws   = 1'b0;
      hash_tgt = '0;
      hash_cnt = '0;
      quotes   = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit is_gap(logic [7:0] c);
      return c == CH_SPACE || c == CH_LF;
    endfunction

    // Characters after which a star with no whitespace before it is binary:
    // underscore, letters, digits, double quote and the three opening brackets.
    function bit binary_follower(logic [7:0] c);
      return c == 8'h5F || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             c == CH_DQ || (c >= 8'h30 && c <= 8'h39) ||
             c == 8'h28 || c == 8'h5B || c == 8'h7B;
    endfunction

    function void conclude(bit ok, logic [1:0] kind, logic [1:0] act);
      res.action = act;
      res.done   = 1'b1;
      res.acc    = ok;
      res.kind   = ok ? kind : KIND_BINARY;
      phase      = PH_IDLE;
    endfunction

    function void push_hash();
      if (hash_tgt >= MAX_HASHES) begin
        conclude(1'b0, KIND_BINARY, ACT_NOT_CONS);
      end else begin
        hash_tgt++;
        phase      = PH_HASHES;
        res.action = ACT_CONSUMED;
      end
    endfunction

    function void body_text(logic [7:0] c);
      phase      = (c == CH_LF) ? PH_BLK_SPACES : PH_BODY;
      res.action = ACT_CONSUMED;
    endfunction

    function void simple_text(logic [7:0] c);
      res.action = ACT_CONSUMED;
      if (c == CH_BSL) begin
        hash_cnt = '0;
        phase    = (hash_tgt == 0) ? PH_ESC_CHAR : PH_ESC_HASH;
      end else if (c == CH_DQ) begin
        if (hash_tgt == 0) begin
          conclude(1'b1, KIND_STRING, ACT_CONSUMED);
        end else begin
          hash_cnt = '0;
          phase    = PH_CLOSE_HASH;
        end
      end else if (c == CH_LF) begin
        conclude(1'b0, KIND_BINARY, ACT_NOT_CONS);
      end else begin
        phase = PH_SIMPLE;
      end
    endfunction

    // Advances the scanner by one accepted character and queues its result.
    function void note_input(bit st, logic [2:0] m, logic [7:0] c, bit eof);
      res.action = ACT_IDLE;
      res.done   = 1'b0;
      res.acc    = 1'b0;
      res.kind   = KIND_BINARY;
      if (st) begin
        clear_scan();
        allowed = m;
        phase   = PH_WS;
      end
      if (phase != PH_IDLE && eof && phase != PH_STAR_NEXT) begin
        conclude(1'b0, KIND_BINARY, ACT_NOT_CONS);
      end else begin
        case (phase)
          PH_WS: begin
            if (is_gap(c)) begin
              saw_ws     = 1'b1;
              res.action = ACT_SKIPPED;
            end else if (c == CH_STAR && (allowed & STAR_BITS) != 0) begin
              phase      = PH_STAR_NEXT;
              res.action = ACT_CONSUMED;
            end else if ((c == CH_HASH || c == CH_SQ || c == CH_DQ) &&
                         allowed[MASK_STRING]) begin
              if (c == CH_HASH) begin
                push_hash();
              end else if (c == CH_SQ) begin
                quotes     = 2'd1;
                phase      = PH_OPEN_Q;
                res.action = ACT_CONSUMED;
              end else begin
                phase      = PH_SIMPLE;
                res.action = ACT_CONSUMED;
              end
            end else begin
              conclude(1'b0, KIND_BINARY, ACT_NOT_CONS);
            end
          end
          PH_STAR_NEXT: begin
            if (!eof && is_gap(c) && saw_ws)
              conclude(1'b1, KIND_BINARY, ACT_NOT_CONS);
            else if (!eof && !saw_ws && binary_follower(c))
              conclude(1'b1, KIND_BINARY, ACT_NOT_CONS);
            else
              conclude(1'b1, KIND_POSTFIX, ACT_NOT_CONS);
          end
          PH_HASHES: begin
            if (c == CH_HASH) begin
              push_hash();
            end else if (c == CH_SQ) begin
              quotes     = 2'd1;
              phase      = PH_OPEN_Q;
              res.action = ACT_CONSUMED;
            end else if (c == CH_DQ) begin
              phase      = PH_SIMPLE;
              res.action = ACT_CONSUMED;
            end else begin
              conclude(1'b0, KIND_BINARY, ACT_NOT_CONS);
            end
          end
          PH_OPEN_Q: begin
            if (c == CH_SQ) begin
              quotes++;
              res.action = ACT_CONSUMED;
              if (quotes >= 3) begin
                quotes = '0;
                phase  = PH_BODY;
              end
            end else begin
              conclude(1'b0, KIND_BINARY, ACT_NOT_CONS);
            end
          end
          PH_BODY: body_text(c);
          PH_BLK_SPACES: begin
            if (c == CH_SPACE) begin
              res.action = ACT_CONSUMED;
            end else if (c == CH_SQ) begin
              quotes     = 2'd1;
              phase      = PH_BLK_QUOTES;
              res.action = ACT_CONSUMED;
            end else begin
              body_text(c);
            end
          end
          PH_BLK_QUOTES: begin
            if (c == CH_SQ) begin
              quotes++;
              res.action = ACT_CONSUMED;
              if (quotes >= 3) begin
                quotes = '0;
                if (hash_tgt == 0) begin
                  conclude(1'b1, KIND_STRING, ACT_CONSUMED);
                end else begin
                  hash_cnt = '0;
                  phase    = PH_BLK_HASHES;
                end
              end
            end else begin
              quotes = '0;
              body_text(c);
            end
          end
          PH_BLK_HASHES: begin
            if (c == CH_HASH) begin
              hash_cnt++;
              res.action = ACT_CONSUMED;
              if (hash_cnt >= hash_tgt) conclude(1'b1, KIND_STRING, ACT_CONSUMED);
            end else begin
              body_text(c);
            end
          end
          PH_SIMPLE: simple_text(c);
          PH_ESC_HASH: begin
            if (c == CH_HASH) begin
              hash_cnt++;
              res.action = ACT_CONSUMED;
              if (hash_cnt >= hash_tgt) phase = PH_ESC_CHAR;
            end else begin
              simple_text(c);
            end
          end
          PH_ESC_CHAR: begin
            if (c == CH_LF) begin
              conclude(1'b0, KIND_BINARY, ACT_NOT_CONS);
            end else begin
              phase      = PH_SIMPLE;
              res.action = ACT_CONSUMED;
            end
          end
          PH_CLOSE_HASH: begin
            if (c == CH_HASH) begin
              hash_cnt++;
              res.action = ACT_CONSUMED;
              if (hash_cnt >= hash_tgt) conclude(1'b1, KIND_STRING, ACT_CONSUMED);
            end else begin
              simple_text(c);
            end
          end
          default: begin
            phase      = PH_IDLE;
            res.action = ACT_IDLE;
          end
        endcase
      end
      expected_q.push_back(res);
    endfunction

    function void mismatch(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compares one result transfer, field by field, with the oldest expectation.
    function void check_result(logic [7:0] d);
      scan_res_t got;
      scan_res_t want;
      got = d[5:0];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $time, d);
        return;
      end
      want = expected_q.pop_front();
      if (got.action != want.action) mismatch("action", want.action, got.action);
      if (got.done != want.done) mismatch("done_res", want.done, got.done);
      if (got.acc != want.acc) mismatch("accepted", want.acc, got.acc);
      if (got.kind != want.kind) mismatch("token_kind", want.kind, got.kind);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [2:0] valid_mask, [10:3] ch, [15:11] zero
  logic [1:0]  in_tuser;   // [0] start_req, [1] at_eof
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [1:0] action, [2] done_res, [3] accepted, [5:4] token_kind

  scan_scoreboard sb;

  // Stimulus controls. quiet switches off idling on both sides for the final
  // stretch; hold_req asks the receiver for one long hold-off.
  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;
  bit         start_pending = 1'b0;
  logic [2:0] scan_mask = '0;
  int         scan_items = 0;
  int         cycles = 0;

  star_and_raw_string_token_scanner_top #(
    .MAX_HASHES(MAX_HASHES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a run that has not finished by the cycle limit has hung.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Transfer monitor. Signals are read right after the edge, before any
  // nonblocking update of that edge lands, so they hold the values the block saw.
  // An input transfer feeds the predictor and a result transfer is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(in_tuser[0], in_tdata[2:0], in_tdata[10:3], in_tuser[1]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
    end
  end

  // Result receiver: random bursts of back-pressure, one long hold-off on request
  // so that the pipeline fills and stalls the input side, none while quiet.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Offers one character and waits for its transfer, sometimes after a gap.
  // tvalid stays high from one transfer to the next unless a gap lowers it.
  task automatic send_char(bit st, logic [2:0] m, logic [7:0] c, bit e);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, c, m};
    in_tuser  <= {e, st};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic open_scan(logic [2:0] m);
    start_pending = 1'b1;
    scan_mask     = m;
  endtask

  // One character of a scan; the first one after open_scan carries the start.
  // On later characters the mask is don't-care, so it is driven at random.
  task automatic scan_item(logic [7:0] c, bit e);
    send_char(start_pending, start_pending ? scan_mask : 3'($urandom), c, e);
    start_pending = 1'b0;
    scan_items++;
  endtask

  task automatic scan_eof();
    scan_item(8'($urandom), 1'b1);
  endtask

  // Characters with no start while the scanner is idle are ignored by the block.
  task automatic idle_tail();
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      send_char(1'b0, 3'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Mostly printable text that cannot close or escape anything; now and then
  // any byte at all.
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    do c = 8'($urandom_range(8'h20, 8'h7E));
    while (c == CH_DQ || c == CH_BSL || c == CH_SQ || c == CH_HASH);
    return c;
  endfunction

  function automatic int pick_hashes();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6:  return 0;
      7, 8, 9, 10, 11:      return $urandom_range(1, 2);
      12, 13, 14:           return 3;
      default:              return $urandom_range(4, 12);
    endcase
  endfunction

  // Mostly with the string bit set, sometimes a mask that rejects the string.
  function automatic logic [2:0] string_mask();
    logic [2:0] m;
    m = 3'($urandom);
    if ($urandom_range(0, 7) != 0) m[MASK_STRING] = 1'b1;
    return m;
  endfunction

  task automatic lead_ws();
    repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0)
      scan_item($urandom_range(0, 1) ? CH_SPACE : CH_LF, 1'b0);
  endtask

  // Star scan: optional whitespace, the star, then a follower of every class.
  task automatic gen_star();
    logic [2:0] m;
    m = 3'($urandom);
    if ($urandom_range(0, 7) != 0) m[1:0] = 2'($urandom_range(1, 3));
    open_scan(m);
    lead_ws();
    scan_item(CH_STAR, 1'b0);
    case ($urandom_range(0, 6))
      0: scan_item(CH_SPACE, 1'b0);
      1: scan_item(CH_LF, 1'b0);
      2: scan_item($urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                        : 8'($urandom_range(8'h41, 8'h5A)), 1'b0);
      3: scan_item(8'($urandom_range(8'h30, 8'h39)), 1'b0);
      4: case ($urandom_range(0, 4))
           0: scan_item(8'h28, 1'b0);
           1: scan_item(8'h5B, 1'b0);
           2: scan_item(8'h7B, 1'b0);
           3: scan_item(8'h5F, 1'b0);
           default: scan_item(CH_DQ, 1'b0);
         endcase
      5: scan_item(8'($urandom), 1'b0);
      default: scan_eof();
    endcase
    idle_tail();
  endtask

  // Simple string with escapes, escapes cut short, false closers, and now and
  // then a newline or end of input that rejects it.
  task automatic gen_simple();
    int h;
    int k;
    h = pick_hashes();
    open_scan(string_mask());
    lead_ws();
    repeat (h) scan_item(CH_HASH, 1'b0);
    scan_item(CH_DQ, 1'b0);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 7))
        0: begin
          scan_item(CH_BSL, 1'b0);
          k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, h) : h;
          repeat (k) scan_item(CH_HASH, 1'b0);
          case ($urandom_range(0, 4))
            0: scan_item(CH_DQ, 1'b0);
            1: scan_item(CH_BSL, 1'b0);
            2: scan_item(CH_LF, 1'b0);
            default: scan_item(plain_byte(), 1'b0);
          endcase
        end
        1: if (h > 0) begin
          scan_item(CH_DQ, 1'b0);
          repeat ($urandom_range(0, h - 1)) scan_item(CH_HASH, 1'b0);
          scan_item(plain_byte(), 1'b0);
        end
        default: scan_item(plain_byte(), 1'b0);
      endcase
    end
    case ($urandom_range(0, 15))
      0: scan_item(CH_LF, 1'b0);
      1: scan_eof();
      default: ;
    endcase
    scan_item(CH_DQ, 1'b0);
    repeat (h) scan_item(CH_HASH, 1'b0);
    idle_tail();
  endtask

  // Block string: lines of text, false closers that break off in the quotes or
  // in the hashes, then a proper closing line.
  task automatic gen_block();
    int h;
    int k;
    h = pick_hashes();
    open_scan(string_mask());
    lead_ws();
    repeat (h) scan_item(CH_HASH, 1'b0);
    if ($urandom_range(0, 15) == 0) begin
      // Opener that breaks off after one or two quotes.
      repeat ($urandom_range(1, 2)) scan_item(CH_SQ, 1'b0);
      scan_item(plain_byte(), 1'b0);
    end else begin
      repeat (3) scan_item(CH_SQ, 1'b0);
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(0, 6))
          scan_item($urandom_range(0, 4) == 0 ? CH_SPACE : plain_byte(), 1'b0);
        scan_item(CH_LF, 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(0, 2)) scan_item(CH_SPACE, 1'b0);
          k = (h > 0) ? $urandom_range(1, 3) : $urandom_range(1, 2);
          repeat (k) scan_item(CH_SQ, 1'b0);
          if (k == 3) repeat ($urandom_range(0, h - 1)) scan_item(CH_HASH, 1'b0);
          scan_item(plain_byte(), 1'b0);
        end
      end
      if ($urandom_range(0, 15) == 0) scan_eof();
      scan_item(CH_LF, 1'b0);
      repeat ($urandom_range(0, 2)) scan_item(CH_SPACE, 1'b0);
      repeat (3) scan_item(CH_SQ, 1'b0);
      repeat (h) scan_item(CH_HASH, 1'b0);
    end
    idle_tail();
  endtask

  // Arbitrary bytes with an arbitrary mask, end of input now and then.
  task automatic gen_noise();
    open_scan(3'($urandom));
    repeat ($urandom_range(1, 4)) scan_item(8'($urandom), $urandom_range(0, 7) == 0);
    idle_tail();
  endtask

  // Stops offering until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A character with no start while idle is ignored.
    send_char(1'b0, 3'b111, CH_STAR, 1'b0);
    // Star right at the start followed by a letter: binary.
    open_scan(3'b001);
    scan_item(CH_STAR, 1'b0);
    scan_item(8'h61, 1'b0);
    // Star with whitespace on both sides: binary, by the postfix bit alone.
    open_scan(3'b010);
    scan_item(CH_SPACE, 1'b0);
    scan_item(CH_STAR, 1'b0);
    scan_item(CH_SPACE, 1'b0);
    // A string scan aborted by a new start, then a star at end of input: postfix.
    open_scan(3'b100);
    scan_item(CH_DQ, 1'b0);
    open_scan(3'b011);
    scan_item(CH_STAR, 1'b0);
    scan_eof();
    // Simple string with an escape.
    open_scan(3'b100);
    scan_item(CH_DQ, 1'b0);
    scan_item(CH_BSL, 1'b0);
    scan_item(8'h6E, 1'b0);
    scan_item(CH_DQ, 1'b0);
    // Newline inside a simple string rejects.
    open_scan(3'b100);
    scan_item(CH_DQ, 1'b0);
    scan_item(CH_LF, 1'b0);
    // Star with no token allowed, end of input at once, an all-ones byte.
    open_scan(3'b000);
    scan_item(CH_STAR, 1'b0);
    open_scan(3'b111);
    scan_eof();
    open_scan(3'b111);
    scan_item(8'hFF, 1'b0);
    // Smallest block string.
    open_scan(3'b100);
    repeat (3) scan_item(CH_SQ, 1'b0);
    scan_item(CH_LF, 1'b0);
    repeat (3) scan_item(CH_SQ, 1'b0);

    // The largest hash count closes properly; one hash more rejects.
    open_scan(3'b100);
    repeat (MAX_HASHES) scan_item(CH_HASH, 1'b0);
    scan_item(CH_DQ, 1'b0);
    scan_item(8'h61, 1'b0);
    scan_item(CH_DQ, 1'b0);
    repeat (MAX_HASHES) scan_item(CH_HASH, 1'b0);
    open_scan(3'b111);
    repeat (MAX_HASHES + 1) scan_item(CH_HASH, 1'b0);

    // Random part, mostly well-formed scans with random content, until the
    // whole run has sent the planned number of characters.
    while (scan_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:               gen_star();
        5, 6, 7, 8, 9, 10:           gen_simple();
        11, 12, 13, 14, 15, 16:      gen_block();
        17, 18:                      gen_noise();
        default: send_char(1'b0, 3'($urandom), 8'($urandom), 1'($urandom));
      endcase
      if (!hold_done && scan_items >= 500) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!pause_done && scan_items >= 900) begin
        pause_done = 1'b1;
        drain();
      end
      if (scan_items >= 1250) quiet = 1'b1;
    end
    in_tvalid <= 1'b0;

    // Let the pipeline empty, then a few more cycles for any stray result.
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
